>>> hw/rtl/bks_pkg.sv
// ---------------------------------------------------------------------------
// bks_pkg: shared constants and helpers
// Widths, arithmetic constants, arctangent table and truncating shifts.
// ---------------------------------------------------------------------------
package bks_pkg;

   localparam int CW = 52;   // CORDIC x/y width
   localparam int ZW = 34;   // CORDIC angle width
   localparam int PW = 70;   // product width
   localparam int MW = 35;   // multiplier operand width
   localparam int DW = 48;   // divider dividend width

   localparam logic signed [CW-1:0] INV_GAIN   = CW'(64'sd652032874);
   localparam logic signed [MW-1:0] STEER_BAM  = MW'(64'sd5468522205);
   localparam logic signed [MW-1:0] TWO_PI_INV = MW'(64'sd41722);
   localparam logic signed [14:0]   STEER_MAX  = 15'sd12800;

   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [ZW-1:0] ang_type;

   function automatic logic [31:0] atan_val(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // shift right, rounding toward zero
   function automatic cord_type tz_cord(input cord_type v, input logic [4:0] sh);
      cord_type n;
      n = -v;
      return v[CW-1] ? -(n >>> sh) : (v >>> sh);
   endfunction

endpackage

>>> hw/rtl/bks_cordic_step.sv
// ---------------------------------------------------------------------------
// bks_cordic_step: one CORDIC micro-rotation
// Rotation mode drives z to zero, vectoring mode drives y to zero.
// ---------------------------------------------------------------------------
module bks_cordic_step (
   input  logic                vec_mode,
   input  logic [4:0]          idx,
   input  bks_pkg::cord_type   x,
   input  bks_pkg::cord_type   y,
   input  bks_pkg::ang_type    z,
   output bks_pkg::cord_type   nx,
   output bks_pkg::cord_type   ny,
   output bks_pkg::ang_type    nz
);
   bks_pkg::cord_type xs, ys;
   bks_pkg::ang_type  a;
   logic              up;

   always_comb begin
      xs = bks_pkg::tz_cord(x, idx);
      ys = bks_pkg::tz_cord(y, idx);
      a  = bks_pkg::ang_type'({2'b00, bks_pkg::atan_val(idx)});
      // up: rotate counterclockwise
      up = vec_mode ? y[bks_pkg::CW-1] : !z[bks_pkg::ZW-1];
      if (up) begin
         nx = x - ys;
         ny = y + xs;
      end else begin
         nx = x + ys;
         ny = y - xs;
      end
      // counterclockwise consumes angle, clockwise adds it back
      if (up) nz = z - a;
      else nz = z + a;
   end
endmodule

>>> hw/rtl/bicycle_kinematic_step.sv
// ---------------------------------------------------------------------------
// bicycle_kinematic_step: kinematic bicycle model, forward Euler
// Advances x, y, heading and time by one sample per step request.
// ---------------------------------------------------------------------------
// A request with restart set loads the start registers into the state and
// returns it through the output register. For a step request the CORDIC
// unit runs four passes (steering rotation, slip-angle vectoring, slip
// rotation, heading rotation), the restoring divider forms a 48-bit
// quotient, and one shared 35x35 multiplier handles the nine products one
// per cycle. req_stall is high for the whole computation; a finished result
// sits in the output register, and a new request is taken while it waits.
// csr writes of zero to the length or step-time registers are dropped.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this.
module bicycle_kinematic_step #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   input  logic signed [15:0] req_speed,
   input  logic signed [14:0] req_steering,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [31:0]        rsp_heading,
   output logic [31:0]        rsp_elapsed,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata
);
   localparam logic [2:0] R_FRONT = 3'd0, R_REAR = 3'd1, R_DT = 3'd2,
                          R_SX = 3'd3, R_SY = 3'd4, R_SH = 3'd5, R_ST = 3'd6;

   localparam logic [4:0] S_IDLE = 5'd0,  S_MDELTA = 5'd1, S_RDINIT = 5'd2,
                          S_RD = 5'd3,    S_MX = 5'd4,     S_MY = 5'd5,
                          S_VINIT = 5'd6, S_VEC = 5'd7,    S_RBINIT = 5'd8,
                          S_RB = 5'd9,    S_RHINIT = 5'd10, S_RH = 5'd11,
                          S_MDTV = 5'd12, S_MSB = 5'd13,   S_DINIT = 5'd14,
                          S_DIV = 5'd15,  S_MQL = 5'd16,   S_MQH = 5'd17,
                          S_MCH = 5'd18,  S_MSH = 5'd19,   S_UPD = 5'd20,
                          S_OUT = 5'd21;

   localparam int CW = bks_pkg::CW;
   localparam int ZW = bks_pkg::ZW;
   localparam int PW = bks_pkg::PW;
   localparam int MW = bks_pkg::MW;
   localparam int DW = bks_pkg::DW;

   // configuration and state
   logic [15:0] front_ff, rear_ff, dt_ff;
   logic [31:0] sx_ff, sy_ff, shd_ff, stm_ff;
   logic [31:0] cur_x_ff, cur_y_ff, cur_h_ff, cur_t_ff;

   logic [4:0] state_ff, state_in;
   logic [5:0] cnt_ff;

   // datapath
   logic signed [14:0] st_ff;
   logic signed [15:0] v_ff;
   bks_pkg::cord_type  x_ff, y_ff, xv_ff;
   bks_pkg::ang_type   z_ff;
   logic               flip_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [33:0] sd_ff, sb_ff, ch_ff, sh_ff;
   logic signed [33:0] dtv_ff;
   logic [31:0]        beta_ff, newh_ff, newx_ff;
   logic [DW-1:0]      dq_ff;
   logic [16:0]        rem_ff;
   logic               qsign_ff;
   logic [39:0]        acc_ff;

   bks_pkg::cord_type nx, ny;
   bks_pkg::ang_type  nz;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [16:0]          total;
   logic signed [33:0]   cos_w, sin_w;
   logic [31:0]          rot_ang;
   bks_pkg::ang_type     z0, zi;
   logic                 flip_i;
   logic                 iter_last, div_last, cordic_st, out_free;
   logic [PW-1:0]        prod_abs;
   logic [17:0]          trial;
   logic [63:0]          dmag;
   logic [31:0]          dphi;
   logic signed [32:0]   sum_y;
   logic [32:0]          sum_t;
   logic signed [PW-1:0] dxy;
   logic signed [14:0]   st_sat;

   assign total     = {1'b0, front_ff} + {1'b0, rear_ff};
   assign cos_w     = flip_ff ? -x_ff[33:0] : x_ff[33:0];
   assign sin_w     = flip_ff ? -y_ff[33:0] : y_ff[33:0];
   assign iter_last = cnt_ff == 6'(ANGLE_ITERATIONS - 1);
   assign div_last  = cnt_ff == 6'(DW - 1);
   assign cordic_st = state_ff == S_RD || state_ff == S_VEC || state_ff == S_RB
                      || state_ff == S_RH;
   assign out_free  = !rsp_valid || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   bks_cordic_step u_cordic (
      .vec_mode (state_ff == S_VEC),
      .idx      (cnt_ff[4:0]),
      .x        (x_ff),
      .y        (y_ff),
      .z        (z_ff),
      .nx       (nx),
      .ny       (ny),
      .nz       (nz)
   );

   // the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MDELTA: begin mul_a = MW'(st_ff); mul_b = bks_pkg::STEER_BAM; end
         S_MX:     begin mul_a = MW'(signed'({1'b0, total})); mul_b = MW'(cos_w); end
         S_MY:     begin mul_a = MW'(signed'({1'b0, front_ff})); mul_b = MW'(sd_ff); end
         S_MDTV:   begin mul_a = MW'(signed'({1'b0, dt_ff})); mul_b = MW'(v_ff); end
         S_MSB:    begin mul_a = MW'(signed'(prod_ff[33:0])); mul_b = MW'(sb_ff); end
         S_MQL:    begin mul_a = MW'(signed'({1'b0, dq_ff[23:0]}));
                         mul_b = bks_pkg::TWO_PI_INV; end
         S_MQH:    begin mul_a = MW'(signed'({1'b0, dq_ff[DW-1:24]}));
                         mul_b = bks_pkg::TWO_PI_INV; end
         S_MCH:    begin mul_a = MW'(dtv_ff); mul_b = MW'(ch_ff); end
         S_MSH:    begin mul_a = MW'(dtv_ff); mul_b = MW'(sh_ff); end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
      mul_p = PW'(mul_a * mul_b);
   end

   // rotation start: fold the angle into +-pi/2
   always_comb begin
      case (state_ff)
         S_RDINIT: rot_ang = prod_ff[47:16] + 32'(prod_ff[PW-1] && prod_ff[15:0] != '0);
         S_RBINIT: rot_ang = z_ff[31:0];
         default:  rot_ang = cur_h_ff + beta_ff;
      endcase
      z0 = ZW'(signed'(rot_ang));
      if (z0 > ZW'(64'sd1073741824)) begin
         zi = z0 - ZW'(64'sd2147483648); flip_i = 1'b1;
      end else if (z0 < -ZW'(64'sd1073741824)) begin
         zi = z0 + ZW'(64'sd2147483648); flip_i = 1'b1;
      end else begin
         zi = z0; flip_i = 1'b0;
      end
   end

   // misc datapath terms
   always_comb begin
      prod_abs = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      trial    = {rem_ff, dq_ff[DW-1]};
      dmag     = {24'd0, acc_ff} + {prod_ff[39:0], 24'd0};
      dphi     = qsign_ff ? -dmag[47:16] : dmag[47:16];
      dxy      = prod_ff[PW-1] ? -PW'((-prod_ff) >>> 38) : (prod_ff >>> 38);
      sum_y    = 33'(signed'(cur_y_ff)) + dxy[32:0];
      sum_t    = {1'b0, cur_t_ff} + {17'd0, dt_ff};
      if (req_steering > bks_pkg::STEER_MAX) st_sat = bks_pkg::STEER_MAX;
      else if (req_steering < -bks_pkg::STEER_MAX) st_sat = -bks_pkg::STEER_MAX;
      else st_sat = req_steering;
   end

   function automatic logic [31:0] sat32(input logic signed [32:0] s);
      if (s > 33'sd2147483647) return 32'h7FFFFFFF;
      if (s < -33'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = req_restart ? S_OUT : S_MDELTA;
         S_MDELTA: state_in = S_RDINIT;
         S_RDINIT: state_in = S_RD;
         S_RD:     if (iter_last) state_in = S_MX;
         S_MX:     state_in = S_MY;
         S_MY:     state_in = S_VINIT;
         S_VINIT:  state_in = S_VEC;
         S_VEC:    if (iter_last) state_in = S_RBINIT;
         S_RBINIT: state_in = S_RB;
         S_RB:     if (iter_last) state_in = S_RHINIT;
         S_RHINIT: state_in = S_RH;
         S_RH:     if (iter_last) state_in = S_MDTV;
         S_MDTV:   state_in = S_MSB;
         S_MSB:    state_in = S_DINIT;
         S_DINIT:  state_in = S_DIV;
         S_DIV:    if (div_last) state_in = S_MQL;
         S_MQL:    state_in = S_MQH;
         S_MQH:    state_in = S_MCH;
         S_MCH:    state_in = S_MSH;
         S_MSH:    state_in = S_UPD;
         S_UPD:    state_in = S_OUT;
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // control, configuration and model state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
         front_ff  <= 16'd256;
         rear_ff   <= 16'd256;
         dt_ff     <= 16'd655;
         sx_ff     <= '0;
         sy_ff     <= '0;
         shd_ff    <= '0;
         stm_ff    <= '0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         cur_h_ff  <= '0;
         cur_t_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if ((cordic_st && iter_last) || (state_ff == S_DIV && div_last)) cnt_ff <= '0;
         else if (cordic_st || state_ff == S_DIV) cnt_ff <= cnt_ff + 6'd1;
         else cnt_ff <= '0;

         if (csr_we) begin
            unique case (csr_addr)
               R_FRONT: if (csr_wdata[15:0] != '0) front_ff <= csr_wdata[15:0];
               R_REAR:  if (csr_wdata[15:0] != '0) rear_ff  <= csr_wdata[15:0];
               R_DT:    if (csr_wdata[15:0] != '0) dt_ff    <= csr_wdata[15:0];
               R_SX:    sx_ff  <= csr_wdata;
               R_SY:    sy_ff  <= csr_wdata;
               R_SH:    shd_ff <= csr_wdata;
               R_ST:    stm_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (state_ff == S_IDLE && req_valid && req_restart) begin
            cur_x_ff <= sx_ff;
            cur_y_ff <= sy_ff;
            cur_h_ff <= shd_ff;
            cur_t_ff <= stm_ff;
         end
         if (state_ff == S_UPD) begin
            cur_x_ff <= newx_ff;
            cur_y_ff <= sat32(sum_y);
            cur_h_ff <= newh_ff;
            cur_t_ff <= sum_t[32] ? 32'hFFFFFFFF : sum_t[31:0];
         end

         if (state_ff == S_OUT && out_free) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (state_ff == S_IDLE) begin
         st_ff <= st_sat;
         v_ff  <= req_speed;
      end
      if (state_ff == S_RDINIT || state_ff == S_RBINIT || state_ff == S_RHINIT) begin
         x_ff    <= bks_pkg::INV_GAIN;
         y_ff    <= '0;
         z_ff    <= zi;
         flip_ff <= flip_i;
      end else if (state_ff == S_VINIT) begin
         x_ff    <= (xv_ff < CW'(1)) ? CW'(1) : xv_ff;
         y_ff    <= prod_ff[CW-1:0];
         z_ff    <= '0;
         flip_ff <= 1'b0;
      end else if (cordic_st) begin
         x_ff <= nx;
         y_ff <= ny;
         z_ff <= nz;
      end
      if (state_ff == S_MX) sd_ff <= sin_w;
      if (state_ff == S_MY) xv_ff <= prod_ff[CW-1:0];
      if (state_ff == S_RBINIT) beta_ff <= z_ff[31:0];
      if (state_ff == S_RHINIT) sb_ff <= sin_w;
      if (state_ff == S_MDTV) begin
         ch_ff <= cos_w;
         sh_ff <= sin_w;
      end
      if (state_ff == S_MSB) dtv_ff <= prod_ff[33:0];
      if (state_ff == S_DINIT) begin
         dq_ff    <= prod_abs[DW+15:16];
         qsign_ff <= prod_ff[PW-1];
         rem_ff   <= '0;
      end else if (state_ff == S_DIV) begin
         if (trial >= {1'b0, total}) begin
            rem_ff <= 17'(trial - {1'b0, total});
            dq_ff  <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[16:0];
            dq_ff  <= {dq_ff[DW-2:0], 1'b0};
         end
      end
      if (state_ff == S_MQH) acc_ff <= prod_ff[39:0];
      if (state_ff == S_MCH) newh_ff <= cur_h_ff + dphi;
      if (state_ff == S_MSH) newx_ff <= sat32(33'(signed'(cur_x_ff)) + dxy[32:0]);
      if (state_ff == S_OUT && out_free) begin
         rsp_pos_x   <= cur_x_ff;
         rsp_pos_y   <= cur_y_ff;
         rsp_heading <= cur_h_ff;
         rsp_elapsed <= cur_t_ff;
      end
   end

endmodule

>>> hw/rtl/bks_checker.sv
// ---------------------------------------------------------------------------
// bks_checker: port-level checks for bicycle_kinematic_step
// Watches the request, response and reset behavior over time.
// ---------------------------------------------------------------------------
module bks_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_restart,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pos_x,
   input logic [31:0] rsp_heading
);
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_heading))
      else $error("stalled response changed");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_restart |=> req_stall)
      else $error("step request did not make the block busy");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

   a_restart_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_restart && !rsp_valid |=> ##1 rsp_valid)
      else $error("restart response late");
endmodule

bind bicycle_kinematic_step bks_checker u_bks_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_restart (req_restart),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pos_x   (rsp_pos_x),
   .rsp_heading (rsp_heading)
);
